### hw/rtl/mpr_pkg.sv
// Package with the shared constants, types and payload structs of the memory pressure regulator.
package mpr_pkg;

    localparam int COUNT_WIDTH     = 40;
    localparam int SUM_WIDTH       = COUNT_WIDTH + 2;
    localparam int UNIT_WIDTH      = (COUNT_WIDTH + 3 > 28) ? COUNT_WIDTH + 3 : 28;
    localparam int LEVEL_WIDTH     = 14;
    localparam int TTL_WIDTH       = 32;
    localparam int THR_WIDTH       = 12;
    localparam int CLASS_WIDTH     = 2;
    localparam int RESERVE_WIDTH   = 7;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int MUL_A_WIDTH     = 32;
    localparam int MUL_B_WIDTH     = 18;
    localparam int PROD_WIDTH      = MUL_A_WIDTH + MUL_B_WIDTH;
    localparam int STEP_WIDTH      = 5;
    localparam int QUOT_WIDTH      = 32;
    localparam int NUM_WIDTH       = 32;
    localparam int THR_NUM_BITS    = 19;

    localparam logic [LEVEL_WIDTH-1:0] SCALE     = 14'd10000;
    localparam logic [LEVEL_WIDTH-1:0] HIGH_CAP  = 14'd9700;
    localparam logic [LEVEL_WIDTH-1:0] LOW_STEP  = 14'd100;
    localparam logic [LEVEL_WIDTH-1:0] HIGH_STEP = 14'd103;
    localparam logic [LEVEL_WIDTH-1:0] THR_MIN   = 14'd3333;
    localparam logic [LEVEL_WIDTH-1:0] THR_DEN   = 14'd10001;
    localparam logic [LEVEL_WIDTH-1:0] DUR_COLD  = 14'd1500;
    localparam logic [LEVEL_WIDTH-1:0] DUR_WARM  = 14'd3000;
    localparam logic [LEVEL_WIDTH-1:0] SQ_LIMIT  = 14'd500;

    localparam logic [MUL_B_WIDTH-1:0]  TTL_GAIN = 18'd250000;
    localparam logic [NUM_WIDTH-1:0]    THR_NUM  = 32'd500000;
    localparam logic [THR_NUM_BITS-1:0] THR_BASE = 19'(500000 / 10001);
    localparam logic [THR_NUM_BITS-1:0] THR_CAP  = 19'd3000;

    localparam logic [RESERVE_WIDTH-1:0] RESERVE_MAX   = 7'd100;
    localparam logic [RESERVE_WIDTH-1:0] RESERVE_RESET = 7'd90;
    localparam logic [TTL_WIDTH-1:0]     BASE_TTL_RESET = 32'd10000000;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESERVE_PERCENT = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_TTL_US     = 1'b1;

    localparam logic [CLASS_WIDTH-1:0] CLASS_COLD = 2'd0;
    localparam logic [CLASS_WIDTH-1:0] CLASS_WARM = 2'd1;
    localparam logic [CLASS_WIDTH-1:0] CLASS_HOT  = 2'd2;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] free_pages;
        logic [COUNT_WIDTH-1:0] hot_pages;
        logic [COUNT_WIDTH-1:0] warm_pages;
        logic [COUNT_WIDTH-1:0] cold_pages;
        logic [CLASS_WIDTH-1:0] region_class;
    } mpr_sample_t;

    typedef struct packed {
        logic [LEVEL_WIDTH-1:0] free_share;
        logic [LEVEL_WIDTH-1:0] low_mark;
        logic [LEVEL_WIDTH-1:0] high_mark;
        logic [LEVEL_WIDTH-1:0] pressure_level;
        logic [TTL_WIDTH-1:0]   current_ttl_us;
        logic [THR_WIDTH-1:0]   throttle_us;
        logic                   duress;
    } mpr_result_t;

    typedef struct packed {
        logic [LEVEL_WIDTH-1:0] low_mark;
        logic [LEVEL_WIDTH-1:0] high_mark;
        logic [TTL_WIDTH-1:0]   base_ttl;
    } mpr_cfg_t;

endpackage

### hw/rtl/mpr_step_unit.sv
// Shared add, compare and conditional subtract unit that performs one quotient step.
module mpr_step_unit
    import mpr_pkg::*;
(
    input  logic [UNIT_WIDTH-1:0] a,
    input  logic [UNIT_WIDTH-1:0] b,
    input  logic                  carry_in,
    input  logic [UNIT_WIDTH-1:0] divisor,
    output logic [UNIT_WIDTH-1:0] remainder,
    output logic                  taken
);

    logic [UNIT_WIDTH-1:0] sum;

    assign sum       = a + b + UNIT_WIDTH'(carry_in);
    assign taken     = (sum >= divisor);
    assign remainder = taken ? (sum - divisor) : sum;

endmodule

### hw/rtl/mpr_core.sv
// Sequencer and datapath that turn one sample into one regulator result.
module mpr_core
    import mpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mpr_cfg_t    cfg,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  mpr_sample_t sample,
    output logic        result_valid,
    input  logic        result_stall,
    output mpr_result_t result
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_TRACK     = 15'b000000000000010,
        S_TOTAL     = 15'b000000000000100,
        S_SHARE_A   = 15'b000000000001000,
        S_SHARE_B   = 15'b000000000010000,
        S_DECIDE    = 15'b000000000100000,
        S_XMUL      = 15'b000000001000000,
        S_XDIV      = 15'b000000010000000,
        S_XSQ       = 15'b000000100000000,
        S_TTLMUL    = 15'b000001000000000,
        S_TTLDIV    = 15'b000010000000000,
        S_THR_SETUP = 15'b000100000000000,
        S_THRDIV    = 15'b001000000000000,
        S_THRFIN    = 15'b010000000000000,
        S_DONE      = 15'b100000000000000
    } state_t;

    localparam logic [STEP_WIDTH-1:0] LEVEL_TOP = STEP_WIDTH'(LEVEL_WIDTH - 1);
    localparam logic [STEP_WIDTH-1:0] QUOT_TOP  = STEP_WIDTH'(QUOT_WIDTH - 1);
    localparam logic [STEP_WIDTH-1:0] THR_TOP   = STEP_WIDTH'(THR_NUM_BITS - 1);

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;

    mpr_sample_t            sample_reg, sample_next;
    mpr_result_t            result_reg, result_next;
    logic [SUM_WIDTH-1:0]   track_reg, track_next;
    logic [UNIT_WIDTH-1:0]  r_reg, r_next;
    logic [UNIT_WIDTH-1:0]  d_reg, d_next;
    logic [QUOT_WIDTH-1:0]  q_reg, q_next;
    logic [NUM_WIDTH-1:0]   num_reg, num_next;
    logic [STEP_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                   zero_reg, zero_next;
    logic [LEVEL_WIDTH-1:0] share_reg, share_next;
    logic [THR_WIDTH-1:0]   thr_reg, thr_next;
    logic [LEVEL_WIDTH-1:0] pressure_reg, pressure_next;
    logic [TTL_WIDTH-1:0]   ttl_now_reg, ttl_now_next;

    logic [UNIT_WIDTH-1:0]  unit_b;
    logic                   unit_cin;
    logic [UNIT_WIDTH-1:0]  unit_rem;
    logic                   unit_taken;
    logic [MUL_A_WIDTH-1:0] mul_a;
    logic [MUL_B_WIDTH-1:0] mul_b;
    logic [PROD_WIDTH-1:0]  prod;
    logic [SUM_WIDTH-1:0]   total;
    logic [LEVEL_WIDTH-1:0] share_v;
    logic [LEVEL_WIDTH-1:0] x_v;
    logic [THR_NUM_BITS-1:0] thr_v;
    logic                   duress_v;
    logic                   accept;

    mpr_step_unit u_step (
        .a         (r_reg),
        .b         (unit_b),
        .carry_in  (unit_cin),
        .divisor   (d_reg),
        .remainder (unit_rem),
        .taken     (unit_taken)
    );

    assign prod = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign total   = SUM_WIDTH'(sample_reg.free_pages) + track_reg;
    assign share_v = zero_reg ? SCALE : (SCALE - q_reg[LEVEL_WIDTH-1:0]);
    assign x_v     = SCALE - q_reg[LEVEL_WIDTH-1:0];
    assign thr_v   = q_reg[THR_NUM_BITS-1:0] - THR_BASE;

    assign duress_v = (pressure_reg >= DUR_COLD) &&
                      ((sample_reg.region_class == CLASS_COLD) ||
                       ((sample_reg.region_class == CLASS_WARM) && (pressure_reg > DUR_WARM)));

    always_comb
    begin
        unit_b   = (state_reg == S_SHARE_B) ? UNIT_WIDTH'(track_reg) : r_reg;
        unit_cin = 1'b0;
        if ((state_reg == S_XDIV) || (state_reg == S_TTLDIV) || (state_reg == S_THRDIV))
        begin
            unit_cin = num_reg[cnt_reg];
        end
        mul_a = MUL_A_WIDTH'(share_reg);
        mul_b = MUL_B_WIDTH'(SCALE);
        if (state_reg == S_XSQ)
        begin
            mul_a = MUL_A_WIDTH'(x_v);
            mul_b = MUL_B_WIDTH'(x_v);
        end
        else if (state_reg == S_TTLMUL)
        begin
            mul_a = cfg.base_ttl;
            mul_b = TTL_GAIN;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        sample_next       = sample_reg;
        result_next       = result_reg;
        track_next        = track_reg;
        r_next            = r_reg;
        d_next            = d_reg;
        q_next            = q_reg;
        num_next          = num_reg;
        cnt_next          = cnt_reg;
        zero_next         = zero_reg;
        share_next        = share_reg;
        thr_next          = thr_reg;
        pressure_next     = pressure_reg;
        ttl_now_next      = ttl_now_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sample_next = sample;
                    state_next  = S_TRACK;
                end
            end
            S_TRACK:
            begin
                track_next = SUM_WIDTH'(sample_reg.hot_pages) +
                             SUM_WIDTH'(sample_reg.warm_pages) +
                             SUM_WIDTH'(sample_reg.cold_pages);
                state_next = S_TOTAL;
            end
            S_TOTAL:
            begin
                d_next     = UNIT_WIDTH'(total);
                zero_next  = (total == '0);
                r_next     = '0;
                q_next     = '0;
                cnt_next   = LEVEL_TOP;
                state_next = (total == '0) ? S_DECIDE : S_SHARE_A;
            end
            S_SHARE_A:
            begin
                r_next = unit_rem;
                q_next = {q_reg[QUOT_WIDTH-2:0], unit_taken};
                if (SCALE[cnt_reg[3:0]])
                begin
                    state_next = S_SHARE_B;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg - STEP_WIDTH'(1);
                end
            end
            S_SHARE_B:
            begin
                r_next = unit_rem;
                q_next = q_reg + QUOT_WIDTH'(unit_taken);
                if (cnt_reg == '0)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cnt_next   = cnt_reg - STEP_WIDTH'(1);
                    state_next = S_SHARE_A;
                end
            end
            S_DECIDE:
            begin
                share_next = share_v;
                if (share_v >= cfg.high_mark)
                begin
                    pressure_next = '0;
                    ttl_now_next  = cfg.base_ttl;
                    state_next    = S_THR_SETUP;
                end
                else if ((share_v < cfg.low_mark) || (pressure_reg != '0))
                begin
                    state_next = S_XMUL;
                end
                else
                begin
                    state_next = S_THR_SETUP;
                end
            end
            S_XMUL:
            begin
                r_next     = UNIT_WIDTH'(prod >> LEVEL_WIDTH);
                num_next   = NUM_WIDTH'(prod[LEVEL_WIDTH-1:0]);
                d_next     = UNIT_WIDTH'(cfg.high_mark);
                q_next     = '0;
                cnt_next   = LEVEL_TOP;
                state_next = S_XDIV;
            end
            S_XDIV:
            begin
                r_next = unit_rem;
                q_next = {q_reg[QUOT_WIDTH-2:0], unit_taken};
                if (cnt_reg == '0)
                begin
                    state_next = S_XSQ;
                end
                else
                begin
                    cnt_next = cnt_reg - STEP_WIDTH'(1);
                end
            end
            S_XSQ:
            begin
                d_next     = UNIT_WIDTH'(prod);
                state_next = S_THR_SETUP;
                if (x_v != pressure_reg)
                begin
                    pressure_next = x_v;
                    if (x_v <= SQ_LIMIT)
                    begin
                        ttl_now_next = cfg.base_ttl;
                    end
                    else
                    begin
                        state_next = S_TTLMUL;
                    end
                end
            end
            S_TTLMUL:
            begin
                r_next     = UNIT_WIDTH'(prod[PROD_WIDTH-1:QUOT_WIDTH]);
                num_next   = prod[NUM_WIDTH-1:0];
                q_next     = '0;
                cnt_next   = QUOT_TOP;
                state_next = S_TTLDIV;
            end
            S_TTLDIV:
            begin
                r_next = unit_rem;
                q_next = {q_reg[QUOT_WIDTH-2:0], unit_taken};
                if (cnt_reg == '0)
                begin
                    ttl_now_next = {q_reg[QUOT_WIDTH-2:0], unit_taken};
                    state_next   = S_THR_SETUP;
                end
                else
                begin
                    cnt_next = cnt_reg - STEP_WIDTH'(1);
                end
            end
            S_THR_SETUP:
            begin
                if (pressure_reg >= THR_MIN)
                begin
                    d_next     = UNIT_WIDTH'(THR_DEN - pressure_reg);
                    r_next     = '0;
                    num_next   = THR_NUM;
                    q_next     = '0;
                    cnt_next   = THR_TOP;
                    state_next = S_THRDIV;
                end
                else
                begin
                    thr_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_THRDIV:
            begin
                r_next = unit_rem;
                q_next = {q_reg[QUOT_WIDTH-2:0], unit_taken};
                if (cnt_reg == '0)
                begin
                    state_next = S_THRFIN;
                end
                else
                begin
                    cnt_next = cnt_reg - STEP_WIDTH'(1);
                end
            end
            S_THRFIN:
            begin
                thr_next   = (thr_v > THR_CAP) ? THR_WIDTH'(THR_CAP) : thr_v[THR_WIDTH-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.free_share     = share_reg;
                    result_next.low_mark       = cfg.low_mark;
                    result_next.high_mark      = cfg.high_mark;
                    result_next.pressure_level = pressure_reg;
                    result_next.current_ttl_us = ttl_now_reg;
                    result_next.throttle_us    = thr_reg;
                    result_next.duress         = duress_v;
                    result_valid_next          = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            pressure_reg     <= '0;
            ttl_now_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            pressure_reg     <= pressure_next;
            ttl_now_reg      <= ttl_now_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        result_reg <= result_next;
        track_reg  <= track_next;
        r_reg      <= r_next;
        d_reg      <= d_next;
        q_reg      <= q_next;
        num_reg    <= num_next;
        cnt_reg    <= cnt_next;
        zero_reg   <= zero_next;
        share_reg  <= share_next;
        thr_reg    <= thr_next;
    end

endmodule

### hw/rtl/memory_pressure_regulator.sv
// Top level of the memory pressure regulator: configuration registers, watermarks and core.
//
// The fastest case is a sample whose counts are all zero, so no division is needed; the slowest
// is one whose pressure changes, so that both the TTL and the throttle delay are recomputed. The
// pace is set by the single add, compare and subtract unit, which performs one quotient step at
// a time for the free share, the new pressure, the TTL and the throttle delay in turn. A result
// that waits on a stall holds the block in its last step. The block takes one sample at a time;
// the next sample is transferred while the previous result still waits in the output register.
// Configuration writes take effect at once and must only be made while the block is idle.
module memory_pressure_regulator
    import mpr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  mpr_sample_t                sample,
    output logic                       result_valid,
    input  logic                       result_stall,
    output mpr_result_t                result
);

    logic [RESERVE_WIDTH-1:0] reserve_reg, reserve_next;
    logic [TTL_WIDTH-1:0]     base_ttl_reg, base_ttl_next;
    logic [RESERVE_WIDTH-1:0] pct;
    logic [LEVEL_WIDTH-1:0]   headroom;
    logic [LEVEL_WIDTH-1:0]   high_raw;
    mpr_cfg_t                 cfg;

    always_comb
    begin
        reserve_next  = reserve_reg;
        base_ttl_next = base_ttl_reg;
        if (cfg_wr_en)
        begin
            if (cfg_index == REG_RESERVE_PERCENT)
            begin
                reserve_next = cfg_data[RESERVE_WIDTH-1:0];
            end
            else if (cfg_index == REG_BASE_TTL_US)
            begin
                base_ttl_next = cfg_data[TTL_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserve_reg  <= RESERVE_RESET;
            base_ttl_reg <= BASE_TTL_RESET;
        end
        else
        begin
            reserve_reg  <= reserve_next;
            base_ttl_reg <= base_ttl_next;
        end
    end

    // The high mark is three percent above the low mark, which is a multiple of one hundred, capped at 9700.
    assign pct      = (reserve_reg > RESERVE_MAX) ? RESERVE_MAX : reserve_reg;
    assign headroom = LEVEL_WIDTH'(RESERVE_MAX - pct);
    assign high_raw = headroom * HIGH_STEP;

    assign cfg.low_mark  = headroom * LOW_STEP;
    assign cfg.high_mark = (high_raw > HIGH_CAP) ? HIGH_CAP : high_raw;
    assign cfg.base_ttl  = base_ttl_reg;

    mpr_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
